/* hdl/uls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Line splitter package
// Shared types and byte codes for the UTF-8 line splitter.
// ---------------------------------------------------------------------------
package uls_pkg;

   localparam int FIELD_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [BYTE_W-1:0] BYTE_END   = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1B;
   localparam logic [BYTE_W-1:0] BYTE_M     = 8'h6D;
   localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC0;
   localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'hFF;

   localparam logic [1:0] ABSORB_LEAD4 = 2'd3;
   localparam logic [1:0] ABSORB_LEAD3 = 2'd2;
   localparam logic [1:0] ABSORB_LEAD2 = 2'd1;

   // What the counter side does with one classified byte
   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,   // count a byte, no width
      OP_CHAR    = 2'd1,   // count a byte and one width
      OP_NEWLINE = 2'd2,   // close the line
      OP_END     = 2'd3    // close the text
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/uls_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one text byte per request.
// ---------------------------------------------------------------------------
interface uls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

/* hdl/uls_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one line record per transfer.
// ---------------------------------------------------------------------------
interface uls_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] line_index;
   logic [15:0] line_start;
   logic [15:0] line_width;
   logic [15:0] line_bytes;
   logic [15:0] text_width;
   logic [15:0] text_bytes;
   logic        final_line;

   modport source (output valid, output line_index, output line_start, output line_width,
                   output line_bytes, output text_width, output text_bytes,
                   output final_line, input ready);
   modport sink   (input valid, input line_index, input line_start, input line_width,
                   input line_bytes, input text_width, input text_bytes,
                   input final_line, output ready);
endinterface

`default_nettype wire

/* hdl/uls_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Line splitter front end
// Tracks character and escape runs and classifies each byte into an op.
// ---------------------------------------------------------------------------
module uls_front (
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     text_byte,
   input  logic           accept,
   output uls_pkg::cmd_type cmd
);
   import uls_pkg::*;

   logic [1:0] absorb_ff, absorb_in;
   logic       esc_ff, esc_in;
   op_type     op;

   always_comb begin
      absorb_in = absorb_ff;
      esc_in    = esc_ff;
      op        = OP_CHAR;
      if (text_byte == BYTE_END) begin
         op        = OP_END;
         absorb_in = '0;
         esc_in    = 1'b0;
      end else if (absorb_ff != '0) begin
         op        = OP_BYTE;
         absorb_in = absorb_ff - 2'd1;
      end else if (esc_ff) begin
         op = OP_BYTE;
         if (text_byte == BYTE_M) begin
            esc_in = 1'b0;
         end
      end else begin
         case (text_byte) inside
            BYTE_LF: begin
               op = OP_NEWLINE;
            end
            BYTE_ESC: begin
               op     = OP_BYTE;
               esc_in = 1'b1;
            end
            [LEAD4_MIN:BYTE_MAX]: begin
               absorb_in = ABSORB_LEAD4;
            end
            [LEAD3_MIN:LEAD4_MIN - 8'd1]: begin
               absorb_in = ABSORB_LEAD3;
            end
            [LEAD2_MIN:LEAD3_MIN - 8'd1]: begin
               absorb_in = ABSORB_LEAD2;
            end
            default: begin
               op = OP_CHAR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         absorb_ff <= '0;
         esc_ff    <= 1'b0;
      end else if (accept) begin
         absorb_ff <= absorb_in;
         esc_ff    <= esc_in;
      end
   end

   assign cmd.valid = accept;
   assign cmd.op    = op;

   // a character run and an escape run never overlap
   assert property (@(posedge clock) disable iff (reset) (absorb_ff != '0) |-> !esc_ff)
      else $error("absorb and escape active together");

endmodule

`default_nettype wire

/* hdl/uls_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Line splitter op queue
// Short FIFO between the classifier and the counter side.
// ---------------------------------------------------------------------------
module uls_queue (
   input  logic             clock,
   input  logic             reset,
   input  uls_pkg::cmd_type push,
   output logic             push_ready,
   output uls_pkg::cmd_type head,
   input  logic             pop
);
   import uls_pkg::*;

   op_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

   assign push_ready = (count_ff != FULL_COUNT);
   assign do_push    = push.valid;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.op    = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("queue occupancy beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == FULL_COUNT) |-> !push.valid)
      else $error("push into full queue");

endmodule

`default_nettype wire

/* hdl/uls_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Line splitter counter side
// Applies ops to the saturating counters and registers line records.
// ---------------------------------------------------------------------------
module uls_back #(
   parameter longint unsigned COUNT_MAX
) (
   input  logic              clock,
   input  logic              reset,
   input  uls_pkg::cmd_type  head,
   output logic              pop,
   uls_rsp_if.source         rsp_chan
);
   import uls_pkg::*;

   localparam int              CNT_W   = $clog2(COUNT_MAX + 64'd1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_MAX);

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
      logic [CNT_W+FIELD_W-1:0] wide;
      wide = {{FIELD_W{1'b0}}, v};
      return wide[FIELD_W-1:0];
   endfunction

   logic [CNT_W-1:0] line_idx_ff, line_idx_in;
   logic [CNT_W-1:0] line_off_ff, line_off_in;
   logic [CNT_W-1:0] lw_ff, lw_in;
   logic [CNT_W-1:0] lb_ff, lb_in;
   logic [CNT_W-1:0] tw_ff, tw_in;
   logic [CNT_W-1:0] tb_ff, tb_in;

   logic                rsp_valid_ff;
   logic [FIELD_W-1:0]  line_index_ff, line_start_ff, line_width_ff, line_bytes_ff;
   logic [FIELD_W-1:0]  text_width_ff, text_bytes_ff;
   logic                final_line_ff;

   logic emits, out_free, load_rsp;

   assign emits    = (head.op == OP_NEWLINE) || (head.op == OP_END);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = head.valid && (!emits || out_free);
   assign load_rsp = pop && emits;

   always_comb begin
      line_idx_in = line_idx_ff;
      line_off_in = line_off_ff;
      lw_in       = lw_ff;
      lb_in       = lb_ff;
      tw_in       = tw_ff;
      tb_in       = tb_ff;
      case (head.op)
         OP_BYTE: begin
            lb_in = sat_inc(lb_ff);
            tb_in = sat_inc(tb_ff);
         end
         OP_CHAR: begin
            lb_in = sat_inc(lb_ff);
            tb_in = sat_inc(tb_ff);
            lw_in = sat_inc(lw_ff);
            tw_in = sat_inc(tw_ff);
         end
         OP_NEWLINE: begin
            tb_in       = sat_inc(tb_ff);
            tw_in       = sat_inc(tw_ff);
            line_idx_in = sat_inc(line_idx_ff);
            line_off_in = sat_inc(tb_ff);
            lw_in       = '0;
            lb_in       = '0;
         end
         OP_END: begin
            line_idx_in = '0;
            line_off_in = '0;
            lw_in       = '0;
            lb_in       = '0;
            tw_in       = '0;
            tb_in       = '0;
         end
         default: begin
            lb_in = lb_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_idx_ff <= '0;
         line_off_ff <= '0;
         lw_ff       <= '0;
         lb_ff       <= '0;
         tw_ff       <= '0;
         tb_ff       <= '0;
      end else if (pop) begin
         line_idx_ff <= line_idx_in;
         line_off_ff <= line_off_in;
         lw_ff       <= lw_in;
         lb_ff       <= lb_in;
         tw_ff       <= tw_in;
         tb_ff       <= tb_in;
      end
   end

   // record register: payload needs no reset
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         line_index_ff <= to_field(line_idx_ff);
         line_start_ff <= to_field(line_off_ff);
         line_width_ff <= to_field(lw_ff);
         line_bytes_ff <= to_field(lb_ff);
         final_line_ff <= (head.op == OP_END);
         if (head.op == OP_END) begin
            text_width_ff <= to_field(tw_ff);
            text_bytes_ff <= to_field(tb_ff);
         end else begin
            text_width_ff <= '0;
            text_bytes_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.line_index = line_index_ff;
   assign rsp_chan.line_start = line_start_ff;
   assign rsp_chan.line_width = line_width_ff;
   assign rsp_chan.line_bytes = line_bytes_ff;
   assign rsp_chan.text_width = text_width_ff;
   assign rsp_chan.text_bytes = text_bytes_ff;
   assign rsp_chan.final_line = final_line_ff;

   assert property (@(posedge clock) disable iff (reset) tb_ff >= lb_ff)
      else $error("line bytes exceed text bytes");

   assert property (@(posedge clock) disable iff (reset) lw_ff <= lb_ff)
      else $error("line width exceeds line bytes");

   assert property (@(posedge clock) disable iff (reset)
      (pop && head.op == OP_END) |=> (tb_ff == '0 && tw_ff == '0 && line_idx_ff == '0))
      else $error("counters not cleared after end of text");

endmodule

`default_nettype wire

/* hdl/utf8_line_splitter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-8 line splitter
// Splits a zero-terminated byte stream into line records with display width.
// ---------------------------------------------------------------------------
// Path: a request that closes a line is classified into the op queue; its op
//   is then popped into the counter update, which loads the record on rsp_chan.
// Throughput: one request per cycle while the op queue has room; the four-entry
//   op queue and the record register let each side stall on its own.
// Reset (synchronous): clears run state, counters, the queue and rsp valid.
// ---------------------------------------------------------------------------
module utf8_line_splitter #(
   parameter longint unsigned COUNT_MAX = 65535
) (
   input  logic      clock,
   input  logic      reset,
   uls_req_if.sink   req_chan,
   uls_rsp_if.source rsp_chan
);
   import uls_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push_ready;
   logic    pop;
   logic    req_accept;

   // take a request whenever the op queue has room; every request yields an op
   assign req_chan.ready = push_ready;
   assign req_accept     = req_chan.valid && push_ready;

   // front: follow character and escape runs, classify the byte
   uls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .text_byte (req_chan.text_byte),
      .accept    (req_accept),
      .cmd       (push_cmd)
   );

   // decouple classification from counting
   uls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_cmd),
      .push_ready (push_ready),
      .head       (head_cmd),
      .pop        (pop)
   );

   // back: saturating counters and the record register; hold an op that
   // closes a line until the record register is free
   uls_back #(
      .COUNT_MAX (COUNT_MAX)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
